@@ src/spdq_pkg.sv @@
// Package for the steering PD controller with squared-error gain.
// Holds the controller states, the datapath command and status types and register indexes.
// No dependencies.
package spdq_pkg;

  localparam int CfgWidth = 16;
  localparam int CfgIndexWidth = 2;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_KP_BASE = 2'd0,
    REG_KP_DIV  = 2'd1,
    REG_KD      = 2'd2,
    REG_CENTER  = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_KP,
    S_MUL_KD,
    S_ADD_SUM,
    S_MUL_DIV,
    S_MUL_SQ,
    S_MUL_CUBE,
    S_ADD_CUBE,
    S_DIV_INIT,
    S_DIV_STEP,
    S_FINISH,
    S_OUTPUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KP,
    MUL_KD,
    MUL_DIVS,
    MUL_SQ,
    MUL_CUBE
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    div_init;
    logic    div_step;
    logic    finish;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } status_t;

endpackage

@@ src/spdq_ctrl.sv @@
// Controller state machine for the steering PD controller.
// Sequences the shared multiplier, the accumulator and the serial divider.
// Depends on spdq_pkg.
module spdq_ctrl #(
  parameter int NUM_W = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  spdq_pkg::status_t status,
  output spdq_pkg::cmd_t   cmd
);
  import spdq_pkg::*;

  localparam int CW = $clog2(NUM_W);

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  logic          count_done;

  assign count_done = (count == CW'(NUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV_STEP) begin
        count <= count + 1'b1;
      end else begin
        count <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_MUL_KP;
      S_MUL_KP:   state_next = S_MUL_KD;
      S_MUL_KD:   state_next = S_ADD_SUM;
      S_ADD_SUM:  state_next = S_MUL_DIV;
      S_MUL_DIV:  state_next = S_MUL_SQ;
      S_MUL_SQ:   state_next = S_MUL_CUBE;
      S_MUL_CUBE: state_next = S_ADD_CUBE;
      S_ADD_CUBE: state_next = S_DIV_INIT;
      S_DIV_INIT: state_next = S_DIV_STEP;
      S_DIV_STEP: if (count_done) state_next = S_FINISH;
      S_FINISH:   state_next = S_OUTPUT;
      S_OUTPUT:   if (!status.out_blocked) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{load: 1'b0, mul_op: MUL_NONE, acc_op: ACC_HOLD, div_init: 1'b0,
            div_step: 1'b0, finish: 1'b0, out_load: 1'b0};
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = ~rst;
        cmd.load = in_valid & ~rst;
      end
      S_MUL_KP:   cmd.mul_op = MUL_KP;
      S_MUL_KD: begin
        cmd.mul_op = MUL_KD;
        cmd.acc_op = ACC_LOAD;
      end
      S_ADD_SUM:  cmd.acc_op = ACC_ADD;
      S_MUL_DIV:  cmd.mul_op = MUL_DIVS;
      S_MUL_SQ: begin
        cmd.mul_op = MUL_SQ;
        cmd.acc_op = ACC_LOAD;
      end
      S_MUL_CUBE: cmd.mul_op = MUL_CUBE;
      S_ADD_CUBE: cmd.acc_op = ACC_ADD;
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV_STEP: cmd.div_step = 1'b1;
      S_FINISH:   cmd.finish = 1'b1;
      S_OUTPUT:   cmd.out_load = !status.out_blocked;
      default: ;
    endcase
  end

endmodule

@@ src/spdq_dp.sv @@
// Datapath for the steering PD controller: error registers, shared multiplier,
// accumulator, restoring divider, saturation and the output register.
// Depends on spdq_pkg.
module spdq_dp #(
  parameter int POSITION_BITS = 12,
  parameter int NUM_W = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  spdq_pkg::cmd_t               cmd,
  output spdq_pkg::status_t            status,
  input  logic [POSITION_BITS-1:0]     target,
  input  logic [POSITION_BITS-1:0]     measured,
  input  logic [spdq_pkg::CfgWidth-1:0] kp_base,
  input  logic [spdq_pkg::CfgWidth-1:0] divisor,
  input  logic [spdq_pkg::CfgWidth-1:0] kd,
  input  logic [spdq_pkg::CfgWidth-1:0] center,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  steer,
  output logic                         saturated
);
  import spdq_pkg::*;

  localparam int E  = POSITION_BITS + 1;
  localparam int AW = (2 * E > POSITION_BITS + 19) ? 2 * E : POSITION_BITS + 19;
  localparam int BW = (E + 1 > CfgWidth + 1) ? E + 1 : CfgWidth + 1;
  localparam int PW = AW + BW;

  logic signed [E-1:0]     error_now;
  logic signed [E:0]       derr_now;
  logic signed [E-1:0]     prev_error;
  logic signed [E-1:0]     err;
  logic signed [E:0]       derr;
  logic signed [AW-1:0]    mul_a;
  logic signed [BW-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;
  logic signed [NUM_W-1:0] prod;
  logic signed [NUM_W-1:0] acc;
  logic [CfgWidth-1:0]     rem;
  logic [NUM_W-1:0]        mag;
  logic                    neg;
  logic signed [NUM_W:0]   diff;
  logic [CfgWidth:0]       rem_shift;
  logic                    rem_ge;
  logic [CfgWidth:0]       rem_sub;
  logic                    in_range;

  assign error_now = $signed({target[POSITION_BITS-1], target})
                   - $signed({measured[POSITION_BITS-1], measured});
  assign derr_now = $signed({error_now[E-1], error_now}) - $signed({prev_error[E-1], prev_error});

  always_comb begin
    unique case (cmd.mul_op)
      MUL_KP: begin
        mul_a = $signed({{(AW-CfgWidth){1'b0}}, kp_base});
        mul_b = $signed({{(BW-E){err[E-1]}}, err});
      end
      MUL_KD: begin
        mul_a = $signed({{(AW-CfgWidth){1'b0}}, kd});
        mul_b = $signed({{(BW-E-1){derr[E]}}, derr});
      end
      MUL_DIVS: begin
        mul_a = acc[AW-1:0];
        mul_b = $signed({{(BW-CfgWidth){1'b0}}, divisor});
      end
      MUL_SQ: begin
        mul_a = $signed({{(AW-E){err[E-1]}}, err});
        mul_b = $signed({{(BW-E){err[E-1]}}, err});
      end
      MUL_CUBE: begin
        mul_a = prod[AW-1:0];
        mul_b = $signed({{(BW-E){err[E-1]}}, err});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign rem_shift = {rem, mag[NUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});
  assign rem_sub   = rem_shift - {1'b0, divisor};

  assign in_range = (&diff[NUM_W:31]) | ~(|diff[NUM_W:31]);

  assign status.out_blocked = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        prev_error <= error_now;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err  <= error_now;
      derr <= derr_now;
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod <= mul_p[NUM_W-1:0];
    end
    unique case (cmd.acc_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      default: ;
    endcase
    if (cmd.div_init) begin
      mag <= acc[NUM_W-1] ? NUM_W'(-acc) : NUM_W'(acc);
      neg <= acc[NUM_W-1];
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_sub[CfgWidth-1:0] : rem_shift[CfgWidth-1:0];
      mag <= {mag[NUM_W-2:0], rem_ge};
    end
    if (cmd.finish) begin
      diff <= neg ? $signed({{(NUM_W+1-CfgWidth){1'b0}}, center}) + $signed({1'b0, mag})
                  : $signed({{(NUM_W+1-CfgWidth){1'b0}}, center}) - $signed({1'b0, mag});
    end
    if (cmd.out_load) begin
      saturated <= ~in_range;
      if (in_range) begin
        steer <= diff[31:0];
      end else if (diff[NUM_W]) begin
        steer <= 32'h8000_0000;
      end else begin
        steer <= 32'h7FFF_FFFF;
      end
    end
  end

endmodule

@@ src/steering_pd_quadratic_gain_core.sv @@
// Top level of the steering PD controller with squared-error gain.
// Holds the configuration registers and joins spdq_ctrl and spdq_dp.
// Depends on spdq_pkg, spdq_ctrl and spdq_dp.

// Each item gives a target and a measured position; the block returns one item
// with steer = center - (e^3 + kp_div*(kp_base*e + kd*de)) / kp_div, truncated
// toward zero and saturated to signed 32 bits, where e = target - measured and
// de is e minus the error of the previous item. A kp_div of zero acts as one.
// One item is processed at a time. After the steps on the single shared
// multiplier and accumulator, the restoring divider produces one quotient bit
// per cycle over the whole NUM_W-bit numerator, where NUM_W =
// max(3*POSITION_BITS, POSITION_BITS+34) + 2, that is 48 at POSITION_BITS = 12.
// A finished result waits in the output register while the next item is taken in.
module steering_pd_quadratic_gain_core #(
  parameter int POSITION_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // target, measured, zero padding
  input  logic [((2*POSITION_BITS+7)/8)*8-1:0]  s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // steer
  output logic [31:0]                           m_tdata,
  // saturated
  output logic                                  m_tuser,
  input  logic                                  cfg_we,
  input  logic [spdq_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [spdq_pkg::CfgWidth-1:0]         cfg_data
);
  import spdq_pkg::*;

  localparam int NUM_W = ((3 * POSITION_BITS > POSITION_BITS + 34) ?
                          3 * POSITION_BITS : POSITION_BITS + 34) + 2;

  logic [CfgWidth-1:0] kp_base;
  logic [CfgWidth-1:0] kp_div;
  logic [CfgWidth-1:0] kd;
  logic [CfgWidth-1:0] center;
  logic [CfgWidth-1:0] divisor;
  cmd_t                cmd;
  status_t             status;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_base <= 16'd257;
      kp_div  <= 16'd80;
      kd      <= 16'd360;
      center  <= 16'd0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_KP_BASE: kp_base <= cfg_data;
        REG_KP_DIV:  kp_div  <= cfg_data;
        REG_KD:      kd      <= cfg_data;
        REG_CENTER:  center  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign divisor = (kp_div == '0) ? CfgWidth'(1) : kp_div;

  spdq_ctrl #(
    .NUM_W(NUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  spdq_dp #(
    .POSITION_BITS(POSITION_BITS),
    .NUM_W        (NUM_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .target    (s_tdata[POSITION_BITS-1:0]),
    .measured  (s_tdata[2*POSITION_BITS-1:POSITION_BITS]),
    .kp_base   (kp_base),
    .divisor   (divisor),
    .kd        (kd),
    .center    (center),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .steer     (m_tdata),
    .saturated (m_tuser)
  );

endmodule
